>>> hdl/gc_pkg.sv
// Shared types and constants for the pixel gamma correction pipeline.
// Holds the log2 table generator used at elaboration; depends on nothing.
`default_nettype none

package gc_pkg;

  localparam int unsigned GammaW     = 16;
  localparam int unsigned CompW      = 8;
  localparam int unsigned CompMax    = 255;
  localparam logic [15:0] GammaReset = 16'd4096;

  typedef struct packed {
    logic vld;
    logic zero;
  } gc_ctl_t;

  // truncated log2 of v (0..255) with fb fractional bits, evaluated at elaboration
  function automatic longint unsigned lg_fixed(input int unsigned v, input int fb);
    longint unsigned m;
    longint unsigned fr;
    int unsigned     n;
    n  = 0;
    fr = 0;
    m  = 0;
    if (v == 0) begin
      return 64'd0;
    end
    for (int k = 0; k < 7; k++) begin
      if ((v >> (k + 1)) != 0) begin
        n = k + 1;
      end
    end
    m = longint'(v) << (30 - n);
    for (int i = fb - 1; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m  = m >> 1;
        fr = fr | (64'd1 << i);
      end
    end
    return (longint'(n) << fb) | fr;
  endfunction

endpackage

`default_nettype wire

>>> hdl/gc_front.sv
// Front of the gamma pipeline: log-distance lookup, then the gamma multiply.
// Depends on gc_pkg for the log2 table generator and control struct.
`default_nettype none

module gc_front #(
  parameter int GAMMA_FRAC_BITS = 12,
  parameter int LOG_FRAC_BITS   = 16,
  parameter int DW              = LOG_FRAC_BITS + 3,
  parameter int EW              = DW + 16 - GAMMA_FRAC_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_vld,
  input  wire logic [7:0]            comp,
  input  wire logic [15:0]           gamma,
  output gc_pkg::gc_ctl_t            ctl_o,
  output logic [EW-1:0]              e_o
);
  import gc_pkg::*;

  logic [DW-1:0]    d_tab [CompMax+1];
  gc_ctl_t          ctl1_r, ctl1_nxt;
  logic [DW-1:0]    d1_r;
  gc_ctl_t          ctl2_r;
  logic [EW-1:0]    e2_r;
  logic [DW+15:0]   prod;

  for (genvar i = 0; i <= CompMax; i++) begin : g_tab
    assign d_tab[i] = DW'(lg_fixed(CompMax, LOG_FRAC_BITS) - lg_fixed(i, LOG_FRAC_BITS));
  end

  always_comb begin
    ctl1_nxt.vld  = in_vld;
    ctl1_nxt.zero = (comp == '0) && (gamma != '0);
  end

  assign prod = (DW+16)'(d1_r) * (DW+16)'(gamma);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      ctl1_r <= ctl1_nxt;
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_r <= d_tab[comp];
    e2_r <= EW'(prod >> GAMMA_FRAC_BITS);
  end

  assign ctl_o = ctl2_r;
  assign e_o   = e2_r;

endmodule

`default_nettype wire

>>> hdl/gc_step.sv
// One bit of the result search: try setting bit BIT, keep it if D(cand) >= E.
// Depends on gc_pkg for the log2 table generator and control struct.
`default_nettype none

module gc_step #(
  parameter int BIT           = 7,
  parameter int LOG_FRAC_BITS = 16,
  parameter int DW            = LOG_FRAC_BITS + 3,
  parameter int EW            = DW + 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire gc_pkg::gc_ctl_t       ctl_i,
  input  wire logic [EW-1:0]         e_i,
  input  wire logic [7:0]            r_i,
  output gc_pkg::gc_ctl_t            ctl_o,
  output logic [EW-1:0]              e_o,
  output logic [7:0]                 r_o
);
  import gc_pkg::*;

  logic [DW-1:0] d_tab [CompMax+1];
  logic [7:0]    cand;
  logic [7:0]    r_nxt;
  gc_ctl_t       ctl_r;
  logic [EW-1:0] e_r;
  logic [7:0]    r_r;

  for (genvar i = 0; i <= CompMax; i++) begin : g_tab
    assign d_tab[i] = DW'(lg_fixed(CompMax, LOG_FRAC_BITS) - lg_fixed(i, LOG_FRAC_BITS));
  end

  always_comb begin
    cand  = r_i | (8'd1 << BIT);
    r_nxt = (EW'(d_tab[cand]) >= e_i) ? cand : r_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    e_r <= e_i;
    r_r <= r_nxt;
  end

  assign ctl_o = ctl_r;
  assign e_o   = e_r;
  assign r_o   = r_r;

endmodule

`default_nettype wire

>>> hdl/pixel_gamma_correction.sv
// Top level of the pixel gamma correction pipeline: gamma register, front, search chain.
// Depends on gc_pkg, gc_front and gc_step.
//
//   channel  ports                                    transfer when
//   input    start, busy, in_component_in             start && !busy
//   result   out_strobe, out_component_out            out_strobe
//   config   cfg_valid, cfg_ready, cfg_data           cfg_valid && cfg_ready
//
// One component enters every cycle; busy stays low.
// Stages in order: log lookup, gamma multiply, then one result bit per stage.
// Synchronous active-low reset clears the valid bits and loads gamma 1.0 (4096).
// The receiver takes every result; nothing in the pipeline stalls.
`default_nettype none

module pixel_gamma_correction #(
  parameter int GAMMA_FRAC_BITS = 12,
  parameter int LOG_FRAC_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  in_component_in,
  output logic             out_strobe,
  output logic [7:0]       out_component_out,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);
  import gc_pkg::*;

  localparam int DW = LOG_FRAC_BITS + 3;
  localparam int EW = DW + GammaW - GAMMA_FRAC_BITS;

  logic [15:0]   gamma_r;
  gc_ctl_t       ctl_s [9];
  logic [EW-1:0] e_s   [8];
  logic [7:0]    r_s   [9];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= GammaReset;
    end else if (cfg_valid && cfg_ready) begin
      gamma_r <= cfg_data;
    end
  end

  gc_front #(
    .GAMMA_FRAC_BITS (GAMMA_FRAC_BITS),
    .LOG_FRAC_BITS   (LOG_FRAC_BITS),
    .DW              (DW),
    .EW              (EW)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_vld(start && !busy),
    .comp  (in_component_in),
    .gamma (gamma_r),
    .ctl_o (ctl_s[0]),
    .e_o   (e_s[0])
  );

  assign r_s[0] = '0;

  for (genvar k = 0; k < 8; k++) begin : g_step
    if (k < 7) begin : g_mid
      gc_step #(
        .BIT           (7 - k),
        .LOG_FRAC_BITS (LOG_FRAC_BITS),
        .DW            (DW),
        .EW            (EW)
      ) u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl_i (ctl_s[k]),
        .e_i   (e_s[k]),
        .r_i   (r_s[k]),
        .ctl_o (ctl_s[k+1]),
        .e_o   (e_s[k+1]),
        .r_o   (r_s[k+1])
      );
    end else begin : g_last
      gc_step #(
        .BIT           (7 - k),
        .LOG_FRAC_BITS (LOG_FRAC_BITS),
        .DW            (DW),
        .EW            (EW)
      ) u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl_i (ctl_s[k]),
        .e_i   (e_s[k]),
        .r_i   (r_s[k]),
        .ctl_o (ctl_s[k+1]),
        .e_o   (),
        .r_o   (r_s[k+1])
      );
    end
  end

  assign out_strobe        = ctl_s[8].vld;
  assign out_component_out = ctl_s[8].zero ? 8'd0 : r_s[8];

endmodule

`default_nettype wire
